>>> src/hss_pkg.sv
// Shared types, constants and the phase table of the half-step sequencer.
`timescale 1ns / 1ps
`default_nettype none

package hss_pkg;

    localparam int REV_STEPS   = 4096;
    localparam int PHASE_COUNT = 8;

    localparam int POS_W   = 16;
    localparam int CNT_W   = 16;
    localparam int DELAY_W = 24;
    localparam int COIL_W  = 4;
    localparam int OP_W    = 2;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd14648;

    localparam logic [OP_W-1:0] OP_MOVE    = 2'd0;
    localparam logic [OP_W-1:0] OP_ENABLE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DISABLE = 2'd2;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd3;

    // eight-phase half-step drive, bit0 is coil one
    localparam logic [COIL_W-1:0] PHASE_TABLE [8] = '{
        4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
    };

    typedef struct packed {
        logic [OP_W-1:0]         opcode;
        logic signed [CNT_W-1:0] move_count;
    } cmd_t;

    function automatic logic [COIL_W-1:0] phase_for(input logic [POS_W-1:0] pos);
        logic [2:0] idx;
        idx = 3'(pos % POS_W'(PHASE_COUNT));
        return PHASE_TABLE[idx];
    endfunction

endpackage

`default_nettype wire

>>> src/hss_ifs.sv
// Request and result channel interfaces of the half-step sequencer.
`timescale 1ns / 1ps
`default_nettype none

interface hss_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [hss_pkg::OP_W-1:0]             opcode;
    logic signed [hss_pkg::CNT_W-1:0]     move_count;

    modport source (output valid, opcode, move_count, input ready);
    modport sink   (input valid, opcode, move_count, output ready);
endinterface

interface hss_res_if;
    logic                                 valid;
    logic                                 ready;
    logic [hss_pkg::COIL_W-1:0]           coil_pattern;
    logic                                 step_taken;
    logic                                 move_rejected;
    logic [hss_pkg::POS_W-1:0]            position;
    logic [hss_pkg::CNT_W-1:0]            steps_pending;
    logic                                 is_enabled;

    modport source (output valid, coil_pattern, step_taken, move_rejected, position,
                    steps_pending, is_enabled, input ready);
    modport sink   (input valid, coil_pattern, step_taken, move_rejected, position,
                    steps_pending, is_enabled, output ready);
endinterface

`default_nettype wire

>>> src/hss_in_stage.sv
// Input register: holds one accepted request until the engine takes it.
`timescale 1ns / 1ps
`default_nettype none

module hss_in_stage (
    input  wire logic          clk,
    input  wire logic          rst_n,
    hss_cmd_if.sink            cmd,
    input  wire logic          adv,
    output logic               item_valid,
    output hss_pkg::cmd_t      item
);

    logic          valid_reg;
    logic          valid_next;
    hss_pkg::cmd_t item_reg;

    // free when empty or when the held request moves on this cycle
    assign cmd.ready  = !valid_reg || adv;
    assign valid_next = (cmd.valid && cmd.ready) || (valid_reg && !adv);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.opcode     <= cmd.opcode;
            item_reg.move_count <= cmd.move_count;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

>>> src/hss_engine.sv
// Sequencer state, next-state logic and the result register.
`timescale 1ns / 1ps
`default_nettype none

module hss_engine (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [hss_pkg::DELAY_W-1:0]   cfg_wdata,
    input  wire logic                          item_valid,
    input  wire hss_pkg::cmd_t                 item,
    output logic                               adv,
    hss_res_if.source                          res
);

    localparam logic [hss_pkg::POS_W:0]   REV_EXT  = (hss_pkg::POS_W+1)'(hss_pkg::REV_STEPS);
    localparam logic [hss_pkg::POS_W-1:0] REV      = hss_pkg::POS_W'(hss_pkg::REV_STEPS);
    localparam logic [hss_pkg::POS_W-1:0] REV_LAST = REV - 1'b1;

    logic [hss_pkg::DELAY_W-1:0] delay_cfg_reg;
    logic [hss_pkg::POS_W-1:0]   pos_reg,  pos_next;
    logic                        dir_reg,  dir_next;
    logic                        en_reg,   en_next;
    logic [hss_pkg::CNT_W-1:0]   rem_reg,  rem_next;
    logic [hss_pkg::DELAY_W-1:0] dly_reg,  dly_next;
    logic [hss_pkg::COIL_W-1:0]  coil_reg, coil_next;

    logic                        out_valid_reg, out_valid_next;
    logic [hss_pkg::COIL_W-1:0]  out_coil_reg;
    logic                        out_step_reg;
    logic                        out_rej_reg;
    logic [hss_pkg::POS_W-1:0]   out_pos_reg;
    logic [hss_pkg::CNT_W-1:0]   out_rem_reg;
    logic                        out_en_reg;

    logic                        stepped;
    logic                        rejected;
    logic                        do_step;
    logic                        step_dir;
    logic [hss_pkg::CNT_W-1:0]   rem_base;
    logic [hss_pkg::CNT_W-1:0]   rem_after;
    logic [hss_pkg::POS_W:0]     pos_inc;
    logic [hss_pkg::POS_W-1:0]   step_pos;
    logic [hss_pkg::DELAY_W-1:0] eff_delay;

    assign adv = item_valid && (!out_valid_reg || res.ready);

    assign eff_delay = (delay_cfg_reg == '0) ? hss_pkg::DELAY_W'(1) : delay_cfg_reg;
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign rem_after = rem_base - 1'b1;

    // position wrap in either direction
    always_comb
    begin
        if (step_dir)
        begin
            step_pos = (pos_inc >= REV_EXT) ? '0 : pos_inc[hss_pkg::POS_W-1:0];
        end
        else if (pos_reg == '0 || pos_reg > REV)
        begin
            step_pos = REV_LAST;
        end
        else
        begin
            step_pos = pos_reg - 1'b1;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        dir_next  = dir_reg;
        en_next   = en_reg;
        rem_next  = rem_reg;
        dly_next  = dly_reg;
        coil_next = coil_reg;
        stepped   = 1'b0;
        rejected  = 1'b0;
        do_step   = 1'b0;
        step_dir  = dir_reg;
        rem_base  = rem_reg;

        case (item.opcode)
            hss_pkg::OP_MOVE:
            begin
                if (rem_reg != '0)
                begin
                    rejected = 1'b1;
                end
                else if (item.move_count != '0)
                begin
                    step_dir = !item.move_count[hss_pkg::CNT_W-1];
                    dir_next = step_dir;
                    // negation of the most negative count gives its magnitude
                    rem_base = item.move_count[hss_pkg::CNT_W-1] ?
                               hss_pkg::CNT_W'(-item.move_count) :
                               hss_pkg::CNT_W'(item.move_count);
                    do_step  = 1'b1;
                end
            end
            hss_pkg::OP_ENABLE:
            begin
                if (!en_reg)
                begin
                    en_next   = 1'b1;
                    coil_next = hss_pkg::phase_for(pos_reg);
                end
            end
            hss_pkg::OP_DISABLE:
            begin
                if (en_reg)
                begin
                    en_next   = 1'b0;
                    coil_next = '0;
                end
            end
            hss_pkg::OP_TICK:
            begin
                if (rem_reg != '0)
                begin
                    if (dly_reg <= hss_pkg::DELAY_W'(1))
                    begin
                        do_step = 1'b1;
                    end
                    else
                    begin
                        dly_next = dly_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (do_step)
        begin
            stepped   = 1'b1;
            pos_next  = step_pos;
            coil_next = hss_pkg::phase_for(step_pos);
            rem_next  = rem_after;
            dly_next  = (rem_after != '0) ? eff_delay : '0;
        end
    end

    assign out_valid_next = adv || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_cfg_reg <= hss_pkg::DELAY_RESET;
            pos_reg       <= '0;
            dir_reg       <= 1'b0;
            en_reg        <= 1'b0;
            rem_reg       <= '0;
            dly_reg       <= '0;
            coil_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                delay_cfg_reg <= cfg_wdata;
            end
            if (adv)
            begin
                pos_reg  <= pos_next;
                dir_reg  <= dir_next;
                en_reg   <= en_next;
                rem_reg  <= rem_next;
                dly_reg  <= dly_next;
                coil_reg <= coil_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_coil_reg <= coil_next;
            out_step_reg <= stepped;
            out_rej_reg  <= rejected;
            out_pos_reg  <= pos_next;
            out_rem_reg  <= rem_next;
            out_en_reg   <= en_next;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.coil_pattern  = out_coil_reg;
    assign res.step_taken    = out_step_reg;
    assign res.move_rejected = out_rej_reg;
    assign res.position      = out_pos_reg;
    assign res.steps_pending = out_rem_reg;
    assign res.is_enabled    = out_en_reg;

endmodule

`default_nettype wire

>>> src/half_step_stepper_sequencer_top.sv
// Top level of the half-step stepper sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Half-step sequencer for a four-coil unipolar stepper. Each request (move,
// enable, disable or one tick of time) yields exactly one result showing the
// state after it. A request is taken into an input register, then updated
// into the result register, so one request per clock is sustained while
// results are taken; a stalled result holds the input register and so
// back-pressures requests. The position wraps modulo REV_STEPS; a move is
// refused while steps remain, takes its first step at once and each later
// one after the configured delay in ticks (0 acts as 1). cfg_wdata written
// with cfg_we sets that delay, reset value 14648.

module half_step_stepper_sequencer_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    hss_cmd_if.sink                            cmd,
    hss_res_if.source                          res,
    input  wire logic                          cfg_we,
    input  wire logic [hss_pkg::DELAY_W-1:0]   cfg_wdata
);

    logic          adv;
    logic          item_valid;
    hss_pkg::cmd_t item;

    hss_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    hss_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .item_valid (item_valid),
        .item       (item),
        .adv        (adv),
        .res        (res)
    );

endmodule

`default_nettype wire

>>> src/hss_chk.sv
// Port-level checks of the half-step sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module hss_chk (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          res_valid,
    input  wire logic                          res_ready,
    input  wire logic [hss_pkg::COIL_W-1:0]    coil_pattern,
    input  wire logic                          step_taken,
    input  wire logic                          move_rejected,
    input  wire logic [hss_pkg::POS_W-1:0]     position,
    input  wire logic [hss_pkg::CNT_W-1:0]     steps_pending
);

    a_step_or_reject: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(step_taken && move_rejected))
        else $error("step and rejection on one result");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (position < hss_pkg::POS_W'(hss_pkg::REV_STEPS)))
        else $error("position beyond one revolution");

    a_reject_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && move_rejected) |-> (steps_pending != '0))
        else $error("move refused with no steps pending");

    a_step_coils: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && step_taken) |-> (coil_pattern != '0))
        else $error("step left the coils undriven");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> (res_valid && $stable(position)
                                       && $stable(steps_pending)))
        else $error("stalled result changed");

endmodule

bind half_step_stepper_sequencer_top hss_chk u_hss_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .coil_pattern  (res.coil_pattern),
    .step_taken    (res.step_taken),
    .move_rejected (res.move_rejected),
    .position      (res.position),
    .steps_pending (res.steps_pending)
);

`default_nettype wire
